// File: rtl/slt_pkg.sv
// Shared types, widths, register indexes and the quarter-wave sine function
// for the tremolo block. No dependencies.
`timescale 1ns / 1ps

package slt_pkg;

   // field widths
   localparam int SAMPLE_W    = 16;
   localparam int PHASE_W     = 32;
   localparam int DEPTH_W     = 16;
   localparam int CNT_REG_W   = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int MAG_W       = 16;
   localparam int GAIN_OP_W   = 17;

   // serial multiplier operand widths
   localparam int MUL_A_W     = 16;
   localparam int MUL_B_W     = 17;

   // parameter defaults
   localparam int DEF_MAX_CHANNELS    = 8;
   localparam int DEF_SINE_TABLE_BITS = 8;

   // Q1.15 unity
   localparam logic [GAIN_OP_W-1:0] Q15_ONE = 17'd32768;

   // reset values of the registers
   localparam logic [PHASE_W-1:0]   RST_PHASE_STEP = 32'd268435;
   localparam logic [DEPTH_W-1:0]   RST_DEPTH      = 16'd6554;
   localparam logic [CNT_REG_W-1:0] RST_CH_COUNT   = 4'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CH_COUNT   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINE,
      ST_MUL_RED,
      ST_MUL_OUT,
      ST_DONE
   } state_type;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Quarter-wave entry idx of a 2^tb table: round(32768*sin(pi/2*(idx+0.5)/2^tb)),
   // odd Taylor terms to x^11 with the angle in Q2.30. Elaboration only.
   function automatic logic [MAG_W-1:0] sine_rom_entry(input int unsigned idx,
                                                       input int unsigned tb);
      longint unsigned x;
      longint unsigned term;
      longint unsigned v;
      longint          sum;
      int unsigned     k;
      x    = (longint'(2 * idx + 1) * HALF_PI_Q30) >> (tb + 1);
      term = x;
      sum  = longint'(x);
      for (k = 1; k <= 5; k++) begin
         term = (((term * x) >> 30) * x) >> 30;
         case (k)
            1: term = term / 6;
            2: term = term / 20;
            3: term = term / 42;
            4: term = term / 72;
            default: term = term / 110;
         endcase
         if (k % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (longint'(sum) * 32768 + (64'd1 << 29)) >> 30;
      if (v > 32768) begin
         v = 32768;
      end
      return v[MAG_W-1:0];
   endfunction

endpackage

// File: rtl/slt_sine_rom.sv
// Quarter-wave sine table with registered read.
// Depends on slt_pkg (entry function, widths).
`timescale 1ns / 1ps

module slt_sine_rom
   import slt_pkg::*;
#(
   parameter int TABLE_BITS = DEF_SINE_TABLE_BITS
) (
   input  logic                  clock,
   input  logic [TABLE_BITS-1:0] addr,
   output logic [MAG_W-1:0]      mag
);

   localparam int DEPTH = 1 << TABLE_BITS;

   logic [MAG_W-1:0] rom_data [DEPTH];
   logic [MAG_W-1:0] mag_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      localparam logic [MAG_W-1:0] ENTRY = sine_rom_entry(i, TABLE_BITS);
      assign rom_data[i] = ENTRY;
   end

   always_ff @(posedge clock) begin
      mag_ff <= rom_data[addr];
   end

   assign mag = mag_ff;

endmodule

// File: rtl/slt_serial_mul.sv
// Radix-4 digit-serial unsigned multiplier: two bits of op_b per cycle,
// low product bits shift out into a register. Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_serial_mul
   import slt_pkg::*;
#(
   parameter int A_W = MUL_A_W,
   parameter int B_W = MUL_B_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [A_W-1:0]               op_a,
   input  logic [B_W-1:0]               op_b,
   output logic                         done,
   output logic [A_W+2*((B_W+1)/2)-1:0] product
);

   localparam int STEPS = (B_W + 1) / 2;
   localparam int LO_W  = 2 * STEPS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [A_W-1:0]   a_ff;
   logic [LO_W-1:0]  b_ff, b_in;
   logic [A_W-1:0]   acc_ff, acc_in;
   logic [LO_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [A_W+1:0]   pp;
   logic [A_W+1:0]   sum;
   logic [LO_W+1:0]  lo_shift;

   always_comb begin
      pp  = (b_ff[0] ? {2'b00, a_ff} : '0) + (b_ff[1] ? {1'b0, a_ff, 1'b0} : '0);
      sum = {2'b00, acc_ff} + pp;
      lo_shift = {sum[1:0], lo_ff} >> 2;
   end

   always_comb begin
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         lo_in   = '0;
         b_in    = LO_W'(op_b);
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum[A_W+1:2];
         lo_in  = lo_shift[LO_W-1:0];
         b_in   = b_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
      end
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = {acc_ff, lo_ff};

endmodule

// File: rtl/sine_lfo_tremolo.sv
// Tremolo top level: registers, sequencer, LFO phase and channel tracking.
// Depends on slt_pkg, slt_sine_rom, slt_serial_mul.
//
//   port group  | direction | moves
//   req_*       | in        | one request: sample_in (signed 16)
//   rsp_*       | out       | one result: sample_out (signed 16)
//   csr_*       | in        | register write: index, data (always ready)
//
// Enabled: each request runs two 9-step radix-4 multiplies on the one serial
// multiplier, plus table read, accept and output load.
// Disabled: accept and output load only; the sample passes straight through.
// Synchronous active-high reset clears control state and sets the registers to their reset values.
// A full result register that is not taken holds the sequencer in its last
// step; the next request is taken once that result moves.
`timescale 1ns / 1ps

module sine_lfo_tremolo
   import slt_pkg::*;
#(
   parameter int MAX_CHANNELS    = DEF_MAX_CHANNELS,
   parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [SAMPLE_W-1:0]   req_sample_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
   localparam int CMP_W  = ((CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W) + 1;
   localparam int PROD_W = MUL_A_W + 2 * ((MUL_B_W + 1) / 2);

   // registers
   logic                   enable_ff;
   logic [PHASE_W-1:0]     phase_step_ff;
   logic [DEPTH_W-1:0]     depth_ff;
   logic                   invert_ff;
   logic [CNT_REG_W-1:0]   ch_count_ff;

   logic [PHASE_W-1:0]     lfo_phase_ff, lfo_phase_in;
   logic [CH_W-1:0]        ch_ff, ch_in;
   state_type              state_ff, state_in;

   logic [SAMPLE_W-1:0]    x_ff;
   logic [SAMPLE_W-1:0]    res_ff, res_in;
   logic [SAMPLE_W-1:0]    rsp_sample_ff;
   logic                   rsp_valid_ff;

   // control
   logic req_take;
   logic mul_start;
   logic mul_sel_out;
   logic res_load;
   logic rsp_load;

   // datapath
   logic [SINE_TABLE_BITS-1:0] rom_idx;
   logic [SINE_TABLE_BITS-1:0] rom_addr;
   logic [MAG_W-1:0]           sine_mag;
   logic                       sine_neg;
   logic [GAIN_OP_W-1:0]       red_op;
   logic [DEPTH_W-1:0]         depth_sat;
   logic [SAMPLE_W-1:0]        abs_x;
   logic [MAG_W-1:0]           gain;
   logic [SAMPLE_W-1:0]        mag_out;
   logic [SAMPLE_W-1:0]        y;
   logic [MUL_A_W-1:0]         mul_a;
   logic [MUL_B_W-1:0]         mul_b;
   logic                       mul_done;
   logic [PROD_W-1:0]          mul_product;
   logic [CMP_W-1:0]           count_sat;
   logic [CMP_W-1:0]           ch_next;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = enable_ff ? ST_SINE : ST_DONE;
            end
         end
         ST_SINE:    state_in = ST_MUL_RED;
         ST_MUL_RED: if (mul_done) state_in = ST_MUL_OUT;
         ST_MUL_OUT: if (mul_done) state_in = ST_DONE;
         ST_DONE:    if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      mul_start   = 1'b0;
      mul_sel_out = 1'b0;
      res_load    = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            res_load  = req_valid && !enable_ff;
         end
         ST_SINE: mul_start = 1'b1;
         ST_MUL_RED: begin
            mul_sel_out = 1'b1;
            mul_start   = mul_done;
         end
         ST_MUL_OUT: res_load = mul_done;
         ST_DONE:    rsp_load = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   assign req_take = req_valid && req_ready;

   // ---------------- sine lookup ----------------
   // quadrant 1 and 3 read the table mirrored, 2 and 3 negate
   assign rom_idx  = lfo_phase_ff[PHASE_W-3 -: SINE_TABLE_BITS];
   assign rom_addr = lfo_phase_ff[PHASE_W-2] ? ~rom_idx : rom_idx;

   slt_sine_rom #(
      .TABLE_BITS (SINE_TABLE_BITS)
   ) u_slt_sine_rom (
      .clock (clock),
      .addr  (rom_addr),
      .mag   (sine_mag)
   );

   // ---------------- arithmetic ----------------
   always_comb begin
      sine_neg  = lfo_phase_ff[PHASE_W-1] ^ (invert_ff & ch_ff[0]);
      // 1 - s in unsigned Q2.15, 0..65536
      red_op    = sine_neg ? (Q15_ONE + GAIN_OP_W'(sine_mag))
                           : (Q15_ONE - GAIN_OP_W'(sine_mag));
      depth_sat = (GAIN_OP_W'(depth_ff) > Q15_ONE) ? Q15_ONE[DEPTH_W-1:0] : depth_ff;
      abs_x     = x_ff[SAMPLE_W-1] ? (~x_ff + 1'b1) : x_ff;
      gain      = Q15_ONE[MAG_W-1:0] - mul_product[16 +: MAG_W];
      mag_out   = mul_product[15 +: SAMPLE_W];
      y         = x_ff[SAMPLE_W-1] ? (~mag_out + 1'b1) : mag_out;
      mul_a     = mul_sel_out ? abs_x : depth_sat;
      mul_b     = mul_sel_out ? MUL_B_W'(gain) : red_op;
      res_in    = (state_ff == ST_IDLE) ? req_sample_in : y;
   end

   slt_serial_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_slt_serial_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   // ---------------- frame tracking ----------------
   always_comb begin
      if (ch_count_ff == '0) begin
         count_sat = CMP_W'(1);
      end else if (CMP_W'(ch_count_ff) > CMP_W'(MAX_CHANNELS)) begin
         count_sat = CMP_W'(MAX_CHANNELS);
      end else begin
         count_sat = CMP_W'(ch_count_ff);
      end
      ch_next      = CMP_W'(ch_ff) + 1'b1;
      ch_in        = ch_ff;
      lfo_phase_in = lfo_phase_ff;
      if (rsp_load && enable_ff) begin
         // last channel, or count lowered to or below the current index
         if (ch_next >= count_sat) begin
            ch_in        = '0;
            lfo_phase_in = lfo_phase_ff + phase_step_ff;
         end else begin
            ch_in = ch_next[CH_W-1:0];
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         phase_step_ff <= RST_PHASE_STEP;
         depth_ff      <= RST_DEPTH;
         invert_ff     <= 1'b0;
         ch_count_ff   <= RST_CH_COUNT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ENABLE:     enable_ff     <= csr_data[0];
            CSR_PHASE_STEP: phase_step_ff <= csr_data[PHASE_W-1:0];
            CSR_DEPTH:      depth_ff      <= csr_data[DEPTH_W-1:0];
            CSR_INVERT:     invert_ff     <= csr_data[0];
            CSR_CH_COUNT:   ch_count_ff   <= csr_data[CNT_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lfo_phase_ff <= '0;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lfo_phase_ff <= lfo_phase_in;
         ch_ff        <= ch_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff <= req_sample_in;
      end
      if (res_load) begin
         res_ff <= res_in;
      end
      if (rsp_load) begin
         rsp_sample_ff <= res_ff;
      end
   end

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = $signed(rsp_sample_ff);

endmodule

// File: rtl/slt_checker.sv
// Port-level checks for the tremolo block, bound to the top level.
// Depends on slt_pkg (sample width).
`timescale 1ns / 1ps

module slt_checker
   import slt_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_sample_out
);

   // requests taken but not yet delivered
   logic [1:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff + {1'b0, req_valid && req_ready} - {1'b0, rsp_valid && rsp_ready};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // one request at a time through the sequencer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample_out)))
      else $error("stalled result changed or dropped");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0))
      else $error("result shown with no request outstanding");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests outstanding");

endmodule

bind sine_lfo_tremolo slt_checker u_slt_checker (.*);

// File: sim/tb_top.sv
// Self-checking bench for sine_lfo_tremolo: directed and random samples through
// the valid/ready channels, predicted with a local LFO/gain model.
// Depends on slt_pkg and the tremolo RTL.
`timescale 1ns / 1ps

module tb_top
   import slt_pkg::*;
();

   localparam int TB_MAX_CH      = DEF_MAX_CHANNELS;
   localparam int TB_TABLE_BITS  = DEF_SINE_TABLE_BITS;
   localparam int TABLE_SIZE     = 1 << TB_TABLE_BITS;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 100;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index      = '0;
   logic [CSR_DATA_W-1:0]      csr_data       = '0;

   sine_lfo_tremolo u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   // shadow registers and LFO state
   logic                 cfg_enable;
   logic [PHASE_W-1:0]   cfg_step;
   logic [DEPTH_W-1:0]   cfg_depth;
   logic                 cfg_invert;
   logic [CNT_REG_W-1:0] cfg_count;
   logic [PHASE_W-1:0]   lfo_phase;
   int unsigned          chan_idx;
   int unsigned          quarter_sine [TABLE_SIZE];

   logic signed [SAMPLE_W-1:0] pending_samples [$];
   logic signed [SAMPLE_W-1:0] expected_out [$];

   bit req_hs, rsp_hs, csr_hs;
   bit idle_on = 1'b1;
   int send_gap = 0;
   int rsp_stall = 0;
   int rsp_holdoff = 0;
   int quiet_cycles = 0;
   int fail_count = 0;
   int checked_count = 0;
   int csr_writes = 0;

   function automatic int unsigned sine_magnitude(input int unsigned entry);
      longint unsigned angle;
      longint unsigned term;
      longint unsigned rounded;
      longint          acc;
      int unsigned     k;
      angle = (64'(2 * entry + 1) * HALF_PI_Q30) / 64'(2 * TABLE_SIZE);
      term  = angle;
      acc   = longint'(angle);
      for (k = 1; k <= 5; k++) begin
         term = (((term * angle) >> 30) * angle) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if (k[0]) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      rounded = (64'(acc) * 64'd32768 + (64'd1 << 29)) >> 30;
      if (rounded > 32768) begin
         rounded = 32768;
      end
      return 32'(rounded);
   endfunction

   // Expected output for one accepted sample; advances LFO state when enabled.
   function automatic logic signed [SAMPLE_W-1:0] tremolo_sample(
      input logic signed [SAMPLE_W-1:0] sample);
      int unsigned frame_len;
      int unsigned tidx;
      int unsigned dep;
      int unsigned cut;
      int unsigned gain;
      int unsigned mag;
      int unsigned scaled;
      int          sine;
      int          xi;
      int          y;
      logic [1:0]  quad;
      if (!cfg_enable) begin
         return sample;
      end
      if (cfg_count == 0) begin
         frame_len = 1;
      end else if (cfg_count > TB_MAX_CH) begin
         frame_len = TB_MAX_CH;
      end else begin
         frame_len = cfg_count;
      end
      quad = lfo_phase[PHASE_W-1 -: 2];
      tidx = lfo_phase[PHASE_W-3 -: TB_TABLE_BITS];
      if (quad[0]) begin
         tidx = TABLE_SIZE - 1 - tidx;
      end
      sine = quad[1] ? -int'(quarter_sine[tidx]) : int'(quarter_sine[tidx]);
      if (cfg_invert && chan_idx[0]) begin
         sine = -sine;
      end
      dep    = (cfg_depth > 32768) ? 32768 : cfg_depth;
      cut    = 32'((64'(dep) * 64'(32768 - sine)) >> 16);
      gain   = 32768 - cut;
      xi     = sample;
      mag    = (xi < 0) ? -xi : xi;
      scaled = (mag * gain) >> 15;
      y      = (xi < 0) ? -int'(scaled) : int'(scaled);
      // a lowered count closes the frame as soon as the index is at or past the end
      if (chan_idx + 1 >= frame_len) begin
         chan_idx  = 0;
         lfo_phase = lfo_phase + cfg_step;
      end else begin
         chan_idx = chan_idx + 1;
      end
      return y[SAMPLE_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return SAMPLE_W'($urandom_range(0, 8) - 4);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
         quarter_sine[i] = sine_magnitude(i);
      end
   end

   // monitor: handshakes, prediction and checking
   always @(posedge clock) begin
      req_hs = !reset && req_valid && req_ready;
      rsp_hs = !reset && rsp_valid && rsp_ready;
      csr_hs = !reset && csr_valid && csr_ready;
      if (reset) begin
         cfg_enable = 1'b0;
         cfg_step   = RST_PHASE_STEP;
         cfg_depth  = RST_DEPTH;
         cfg_invert = 1'b0;
         cfg_count  = RST_CH_COUNT;
         lfo_phase  = '0;
         chan_idx   = 0;
      end else begin
         if (rsp_hs) begin
            if (expected_out.size() == 0) begin
               $error("unexpected result: sample_out %0d", rsp_sample_out);
               fail_count++;
            end else begin
               logic signed [SAMPLE_W-1:0] want;
               want = expected_out.pop_front();
               checked_count++;
               if (rsp_sample_out !== want) begin
                  $error("sample_out mismatch: expected %0d, actual %0d", want, rsp_sample_out);
                  fail_count++;
               end
            end
         end
         if (req_hs) begin
            expected_out.push_back(tremolo_sample(req_sample_in));
         end
         if (csr_hs) begin
            csr_writes++;
            case (csr_index)
               CSR_ENABLE:     cfg_enable = csr_data[0];
               CSR_PHASE_STEP: cfg_step   = csr_data[PHASE_W-1:0];
               CSR_DEPTH:      cfg_depth  = csr_data[DEPTH_W-1:0];
               CSR_INVERT:     cfg_invert = csr_data[0];
               CSR_CH_COUNT:   cfg_count  = csr_data[CNT_REG_W-1:0];
               default: ;
            endcase
         end
         quiet_cycles = (req_hs || rsp_hs || csr_hs) ? 0 : quiet_cycles + 1;
      end
   end

   // request driver
   always @(negedge clock) begin
      bit launch;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         launch = req_valid && !req_hs;
         if (!launch) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_samples.size() != 0) begin
               req_sample_in <= pending_samples.pop_front();
               launch   = 1'b1;
               send_gap = idle_on ? $urandom_range(0, 7) : 0;
            end
         end
         req_valid <= launch;
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_hs) begin
            rsp_stall = idle_on ? $urandom_range(0, 7) : 0;
         end
         if (rsp_holdoff > 0) begin
            rsp_holdoff--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_valid || expected_out.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) begin
         pending_samples.push_back(draw_sample());
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] v;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bypass at reset settings
      pending_samples.push_back(16'sh7fff);
      pending_samples.push_back(16'sh8000);
      wait_drained();

      // full depth, quarter-turn steps: one sample per quadrant
      write_csr(CSR_ENABLE, 1);
      write_csr(CSR_DEPTH, 32768);
      write_csr(CSR_PHASE_STEP, 32'h4000_0000);
      write_csr(CSR_CH_COUNT, 1);
      pending_samples = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, -16'sd1, 16'sd1};
      wait_drained();

      // depth above full, odd channels inverted
      write_csr(CSR_DEPTH, 32'h0000_ffff);
      write_csr(CSR_INVERT, 1);
      write_csr(CSR_CH_COUNT, 2);
      write_csr(CSR_PHASE_STEP, 32'h2000_0000);
      pending_samples = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
      wait_drained();

      // zero count acts as one channel, oversize count clamps
      write_csr(CSR_CH_COUNT, 0);
      pending_samples = '{16'sd20000, -16'sd20000, 16'sd1};
      wait_drained();
      write_csr(CSR_CH_COUNT, 15);
      queue_random(3);
      wait_drained();

      // count lowered while mid-frame
      write_csr(CSR_CH_COUNT, 6);
      queue_random(4);
      wait_drained();
      write_csr(CSR_CH_COUNT, 2);
      queue_random(2);
      wait_drained();

      // unmapped indexes are ignored; bypass holds the LFO
      for (int i = CSR_CH_COUNT + 1; i < (1 << CSR_IDX_W); i++) begin
         write_csr(CSR_IDX_W'(i), $urandom);
      end
      write_csr(CSR_ENABLE, 0);
      queue_random(2);
      wait_drained();
      write_csr(CSR_ENABLE, 1);
      queue_random(2);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            write_csr(CSR_ENABLE, 1);
            write_csr(CSR_PHASE_STEP, 32'hffff_ffff);
            write_csr(CSR_DEPTH, 32768);
            write_csr(CSR_INVERT, 1);
            write_csr(CSR_CH_COUNT, TB_MAX_CH);
         end else if (p == 1) begin
            write_csr(CSR_ENABLE, 1);
            write_csr(CSR_PHASE_STEP, 0);
            write_csr(CSR_DEPTH, 0);
            write_csr(CSR_INVERT, 0);
            write_csr(CSR_CH_COUNT, 1);
         end else begin
            v = $urandom;
            write_csr(CSR_ENABLE, {v[31:1], 1'($urandom_range(0, 4) != 0)});
            case ($urandom_range(0, 4))
               0: v = 0;
               1: v = 32'hffff_ffff;
               2: v = $urandom_range(0, 1 << 20);
               default: v = $urandom;
            endcase
            write_csr(CSR_PHASE_STEP, v);
            case ($urandom_range(0, 5))
               0: v = 0;
               1: v = 32768;
               2: v = $urandom_range(32769, 65535);
               default: v = $urandom_range(0, 32768);
            endcase
            write_csr(CSR_DEPTH, {16'($urandom), v[15:0]});
            write_csr(CSR_INVERT, $urandom);
            v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            write_csr(CSR_CH_COUNT, {28'($urandom), v[3:0]});
            if ($urandom_range(0, 2) == 0) begin
               write_csr(CSR_IDX_W'($urandom_range(CSR_CH_COUNT + 1, (1 << CSR_IDX_W) - 1)),
                         $urandom);
            end
         end
         idle_on = ($urandom_range(0, 3) != 0);
         if (p == 2) begin
            // back-pressure: sender streams while the receiver sits out
            idle_on     = 1'b0;
            rsp_holdoff = HOLDOFF_CYCLES;
         end
         if (p == 5) begin
            // sender stops until every result is back, then resumes
            queue_random(PHASE_ITEMS / 2);
            wait_drained();
            queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            queue_random(PHASE_ITEMS);
         end
         wait_drained();
      end

      $display("Checked %0d samples over %0d register writes: bypass, full and over-range",
               checked_count, csr_writes);
      $display("depth, inverted channels, counts 0..15, mid-frame count changes, back-pressure.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/slt_pkg.sv
rtl/slt_sine_rom.sv
rtl/slt_serial_mul.sv
rtl/sine_lfo_tremolo.sv
rtl/slt_checker.sv
sim/tb_top.sv
